[src/jss_pkg.sv]
`default_nettype none
package jss_pkg;

	localparam int SHIFT_WIDTH  = 32;
	localparam int DATA_W       = 32;
	localparam int CNT_W        = $clog2(SHIFT_WIDTH + 1);
	localparam int POS_W        = $clog2(SHIFT_WIDTH);
	localparam int RESET_PULSES = 5;
	localparam int IR_PREFIX    = 5;
	localparam int DR_PREFIX    = 4;

	typedef enum logic [2:0] {
		OP_TICK      = 3'd0,
		OP_TAP_RESET = 3'd1,
		OP_GO_IDLE   = 3'd2,
		OP_SHIFT_IR  = 3'd3,
		OP_SHIFT_DR  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_RESET  = 3'd1,
		PH_GOIDLE = 3'd2,
		PH_PREFIX = 3'd3,
		PH_SHIFT  = 3'd4,
		PH_EXIT   = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_IR   = 2'd1,
		KIND_DR   = 2'd2
	} kind_t;

	typedef struct packed {
		logic [2:0]        operation;
		logic [DATA_W-1:0] shift_value;
		logic [5:0]        shift_length;
		logic              tdo_level;
	} item_t;

	typedef struct packed {
		logic              tms_out;
		logic              tdi_out;
		logic              pulse;
		logic              busy_res;
		logic              done_res;
		logic [DATA_W-1:0] captured_data;
		logic              rejected;
	} res_t;

endpackage
`default_nettype wire

[src/jtag_scan_sequencer_top.sv]
// An accepted request is registered into the item stage; its result is then registered into the result register.
// Throughput: one request per cycle; stalls only while the result register is full and stalled.
// Each tick request gives one TCK pulse decision from the sequencer state in the core stage.
// Reset (arst_n low) empties both stages and returns the sequencer to idle with zeroed state.
`default_nettype none
module jtag_scan_sequencer_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  operation,
	input  wire logic [31:0] shift_value,
	input  wire logic [5:0]  shift_length,
	input  wire logic        tdo_level,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             tms_out,
	output logic             tdi_out,
	output logic             pulse,
	output logic             busy_res,
	output logic             done_res,
	output logic [31:0]      captured_data,
	output logic             rejected
);

	logic           advance;
	logic           valid_s1;
	jss_pkg::item_t item_s1;
	jss_pkg::res_t  res_d;
	jss_pkg::res_t  res_q;
	logic           out_valid_q;

	assign advance  = !(out_valid_q && out_stall);
	assign in_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= in_valid;
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			item_s1.operation    <= operation;
			item_s1.shift_value  <= shift_value;
			item_s1.shift_length <= shift_length;
			item_s1.tdo_level    <= tdo_level;
		end
		if (advance && valid_s1) begin
			res_q <= res_d;
		end
	end

	jss_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance && valid_s1),
		.item    (item_s1),
		.res     (res_d)
	);

	assign out_valid     = out_valid_q;
	assign tms_out       = res_q.tms_out;
	assign tdi_out       = res_q.tdi_out;
	assign pulse         = res_q.pulse;
	assign busy_res      = res_q.busy_res;
	assign done_res      = res_q.done_res;
	assign captured_data = res_q.captured_data;
	assign rejected      = res_q.rejected;

endmodule
`default_nettype wire

[src/jss_core.sv]
`default_nettype none
module jss_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step_en,
	input  wire jss_pkg::item_t item,
	output jss_pkg::res_t       res
);

	jss_pkg::phase_t                  phase_q, phase_d;
	jss_pkg::kind_t                   scan_kind_q, scan_kind_d;
	logic [jss_pkg::CNT_W-1:0]        step_count_q, step_count_d;
	logic [jss_pkg::CNT_W-1:0]        bit_total_q, bit_total_d;
	logic [jss_pkg::SHIFT_WIDTH-1:0]  out_shift_q, out_shift_d;
	logic [jss_pkg::SHIFT_WIDTH-1:0]  in_capture_q, in_capture_d;
	logic                             capture_pending_q, capture_pending_d;
	logic [jss_pkg::POS_W-1:0]        cap_pos_q, cap_pos_d;
	logic [jss_pkg::CNT_W:0]          step_inc;
	logic                             is_ir;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= jss_pkg::PH_IDLE;
			scan_kind_q       <= jss_pkg::KIND_NONE;
			step_count_q      <= '0;
			bit_total_q       <= '0;
			out_shift_q       <= '0;
			in_capture_q      <= '0;
			capture_pending_q <= 1'b0;
			cap_pos_q         <= '0;
		end else begin
			phase_q           <= phase_d;
			scan_kind_q       <= scan_kind_d;
			step_count_q      <= step_count_d;
			bit_total_q       <= bit_total_d;
			out_shift_q       <= out_shift_d;
			in_capture_q      <= in_capture_d;
			capture_pending_q <= capture_pending_d;
			cap_pos_q         <= cap_pos_d;
		end
	end

	assign step_inc = (jss_pkg::CNT_W+1)'(step_count_q) + (jss_pkg::CNT_W+1)'(1);
	assign is_ir    = (scan_kind_q == jss_pkg::KIND_IR);

	always_comb begin
		phase_d           = phase_q;
		scan_kind_d       = scan_kind_q;
		step_count_d      = step_count_q;
		bit_total_d       = bit_total_q;
		out_shift_d       = out_shift_q;
		in_capture_d      = in_capture_q;
		capture_pending_d = capture_pending_q;
		cap_pos_d         = cap_pos_q;
		res.tms_out       = 1'b0;
		res.tdi_out       = 1'b0;
		res.pulse         = 1'b0;
		res.done_res      = 1'b0;
		res.rejected      = 1'b0;
		if (step_en) begin
			case (jss_pkg::op_t'(item.operation))
				jss_pkg::OP_TAP_RESET, jss_pkg::OP_GO_IDLE,
				jss_pkg::OP_SHIFT_IR, jss_pkg::OP_SHIFT_DR: begin
					if (phase_q != jss_pkg::PH_IDLE) begin
						res.rejected = 1'b1;
					end else begin
						in_capture_d      = '0;
						capture_pending_d = 1'b0;
						step_count_d      = '0;
						cap_pos_d         = '0;
						if (item.operation == jss_pkg::OP_TAP_RESET) begin
							phase_d     = jss_pkg::PH_RESET;
							scan_kind_d = jss_pkg::KIND_NONE;
						end else if (item.operation == jss_pkg::OP_GO_IDLE) begin
							phase_d     = jss_pkg::PH_GOIDLE;
							scan_kind_d = jss_pkg::KIND_NONE;
						end else begin
							if (item.shift_length == '0) begin
								bit_total_d = jss_pkg::CNT_W'(1);
							end else if (int'(item.shift_length) > jss_pkg::SHIFT_WIDTH) begin
								bit_total_d = jss_pkg::CNT_W'(jss_pkg::SHIFT_WIDTH);
							end else begin
								bit_total_d = jss_pkg::CNT_W'(item.shift_length);
							end
							phase_d = jss_pkg::PH_PREFIX;
							if (item.operation == jss_pkg::OP_SHIFT_IR) begin
								scan_kind_d = jss_pkg::KIND_IR;
								out_shift_d = jss_pkg::SHIFT_WIDTH'(item.shift_value);
							end else begin
								scan_kind_d = jss_pkg::KIND_DR;
								out_shift_d = '0;
							end
						end
					end
				end
				jss_pkg::OP_TICK: begin
					if (phase_q != jss_pkg::PH_IDLE) begin
						if (capture_pending_q) begin
							in_capture_d[cap_pos_q] = in_capture_q[cap_pos_q] | item.tdo_level;
							capture_pending_d       = 1'b0;
						end
						res.pulse = 1'b1;
						case (phase_q)
							jss_pkg::PH_RESET: begin
								res.tms_out  = 1'b1;
								step_count_d = step_inc[jss_pkg::CNT_W-1:0];
								if (int'(step_inc) >= jss_pkg::RESET_PULSES) begin
									res.done_res = 1'b1;
									phase_d      = jss_pkg::PH_IDLE;
									step_count_d = '0;
								end
							end
							jss_pkg::PH_GOIDLE: begin
								res.done_res = 1'b1;
								phase_d      = jss_pkg::PH_IDLE;
								step_count_d = '0;
							end
							jss_pkg::PH_PREFIX: begin
								res.tms_out  = (step_count_q == jss_pkg::CNT_W'(1)) ||
									(is_ir && step_count_q == jss_pkg::CNT_W'(2));
								step_count_d = step_inc[jss_pkg::CNT_W-1:0];
								if (int'(step_inc) >= (is_ir ? jss_pkg::IR_PREFIX
									: jss_pkg::DR_PREFIX)) begin
									phase_d      = jss_pkg::PH_SHIFT;
									step_count_d = '0;
								end
							end
							jss_pkg::PH_SHIFT: begin
								res.tdi_out       = out_shift_q[0];
								out_shift_d       = out_shift_q >> 1;
								res.tms_out       = (step_inc >= (jss_pkg::CNT_W+1)'(bit_total_q));
								cap_pos_d         = step_count_q[jss_pkg::POS_W-1:0];
								capture_pending_d = 1'b1;
								step_count_d      = step_inc[jss_pkg::CNT_W-1:0];
								if (step_inc >= (jss_pkg::CNT_W+1)'(bit_total_q)) begin
									phase_d      = jss_pkg::PH_EXIT;
									step_count_d = '0;
								end
							end
							jss_pkg::PH_EXIT: begin
								if (step_count_q == '0) begin
									res.tms_out  = 1'b1;
									step_count_d = jss_pkg::CNT_W'(1);
								end else begin
									res.done_res = 1'b1;
									phase_d      = jss_pkg::PH_IDLE;
									step_count_d = '0;
									scan_kind_d  = jss_pkg::KIND_NONE;
								end
							end
							default: begin
								res.pulse    = 1'b0;
								phase_d      = jss_pkg::PH_IDLE;
								step_count_d = '0;
							end
						endcase
					end
				end
				default: begin
				end
			endcase
		end
		res.busy_res      = (phase_d != jss_pkg::PH_IDLE);
		res.captured_data = jss_pkg::DATA_W'(in_capture_d);
	end

endmodule
`default_nettype wire

[bench/jtag_scan_sequencer_top_tb.sv]
`default_nettype none
module jtag_scan_sequencer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_MID   = 3'd6;
	localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
	localparam int IR_PATTERN = 'h06;
	localparam int DR_PATTERN = 'h02;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 10;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  operation = '0;
	logic [31:0] shift_value = '0;
	logic [5:0]  shift_length = '0;
	logic        tdo_level = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        tms_out;
	logic        tdi_out;
	logic        pulse;
	logic        busy_res;
	logic        done_res;
	logic [31:0] captured_data;
	logic        rejected;

	jtag_scan_sequencer_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.shift_value(shift_value),
		.shift_length(shift_length),
		.tdo_level(tdo_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.tms_out(tms_out),
		.tdi_out(tdi_out),
		.pulse(pulse),
		.busy_res(busy_res),
		.done_res(done_res),
		.captured_data(captured_data),
		.rejected(rejected)
	);

	always #5 clk = ~clk;

	jss_pkg::item_t pending_reqs[$];
	jss_pkg::res_t  expected_pulses[$];
	jss_pkg::item_t queued_req;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int          errors = 0;
	int          items_made = 0;
	int          quiet_cycles = 0;

	jss_pkg::phase_t seq_phase = jss_pkg::PH_IDLE;
	jss_pkg::kind_t  seq_kind = jss_pkg::KIND_NONE;
	logic [5:0]  seq_step = '0;
	logic [5:0]  seq_len = '0;
	logic [31:0] seq_tx = '0;
	logic [31:0] seq_rx = '0;
	logic        seq_rx_pending = 1'b0;
	logic [4:0]  seq_rx_pos = '0;

	wire req_taken = in_valid && !in_stall;
	wire res_taken = out_valid && !out_stall;

	function automatic jss_pkg::res_t predict_pulse(jss_pkg::item_t it);
		jss_pkg::res_t r;
		logic [5:0]    len;
		int            pattern;
		int            plen;
		r = '0;
		len = it.shift_length;
		case (it.operation)
			jss_pkg::OP_TAP_RESET, jss_pkg::OP_GO_IDLE,
			jss_pkg::OP_SHIFT_IR, jss_pkg::OP_SHIFT_DR: begin
				if (seq_phase != jss_pkg::PH_IDLE) begin
					r.rejected = 1'b1;
				end else begin
					seq_rx = '0;
					seq_rx_pending = 1'b0;
					seq_step = '0;
					seq_rx_pos = '0;
					if (it.operation == jss_pkg::OP_TAP_RESET) begin
						seq_phase = jss_pkg::PH_RESET;
						seq_kind = jss_pkg::KIND_NONE;
					end else if (it.operation == jss_pkg::OP_GO_IDLE) begin
						seq_phase = jss_pkg::PH_GOIDLE;
						seq_kind = jss_pkg::KIND_NONE;
					end else begin
						if (len == 0)
							len = 6'd1;
						if (len > jss_pkg::SHIFT_WIDTH)
							len = 6'(jss_pkg::SHIFT_WIDTH);
						seq_len = len;
						seq_phase = jss_pkg::PH_PREFIX;
						seq_kind = (it.operation == jss_pkg::OP_SHIFT_IR) ?
							jss_pkg::KIND_IR : jss_pkg::KIND_DR;
						seq_tx = (it.operation == jss_pkg::OP_SHIFT_IR) ? it.shift_value : '0;
					end
				end
			end
			jss_pkg::OP_TICK: begin
				if (seq_phase != jss_pkg::PH_IDLE) begin
					if (seq_rx_pending) begin
						if (it.tdo_level)
							seq_rx[seq_rx_pos] = 1'b1;
						seq_rx_pending = 1'b0;
					end
					r.pulse = 1'b1;
					case (seq_phase)
						jss_pkg::PH_RESET: begin
							r.tms_out = 1'b1;
							seq_step++;
							if (seq_step >= jss_pkg::RESET_PULSES) begin
								r.done_res = 1'b1;
								seq_phase = jss_pkg::PH_IDLE;
								seq_step = '0;
							end
						end
						jss_pkg::PH_GOIDLE: begin
							r.done_res = 1'b1;
							seq_phase = jss_pkg::PH_IDLE;
							seq_step = '0;
						end
						jss_pkg::PH_PREFIX: begin
							pattern = (seq_kind == jss_pkg::KIND_IR) ? IR_PATTERN : DR_PATTERN;
							plen = (seq_kind == jss_pkg::KIND_IR) ? jss_pkg::IR_PREFIX :
								jss_pkg::DR_PREFIX;
							r.tms_out = pattern[seq_step[2:0]];
							seq_step++;
							if (seq_step >= plen) begin
								seq_phase = jss_pkg::PH_SHIFT;
								seq_step = '0;
							end
						end
						jss_pkg::PH_SHIFT: begin
							r.tdi_out = seq_tx[0];
							seq_tx = seq_tx >> 1;
							r.tms_out = (seq_step + 7'd1 >= seq_len);
							seq_rx_pos = seq_step[4:0];
							seq_rx_pending = 1'b1;
							seq_step++;
							if (seq_step >= seq_len) begin
								seq_phase = jss_pkg::PH_EXIT;
								seq_step = '0;
							end
						end
						jss_pkg::PH_EXIT: begin
							if (seq_step == 0) begin
								r.tms_out = 1'b1;
								seq_step = 6'd1;
							end else begin
								r.done_res = 1'b1;
								seq_phase = jss_pkg::PH_IDLE;
								seq_step = '0;
								seq_kind = jss_pkg::KIND_NONE;
							end
						end
						default: begin
							r.pulse = 1'b0;
							seq_phase = jss_pkg::PH_IDLE;
							seq_step = '0;
						end
					endcase
				end
			end
			default: ;
		endcase
		r.busy_res = (seq_phase != jss_pkg::PH_IDLE);
		r.captured_data = seq_rx;
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			$error("%s: expected %0h, got %0h", name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
			if (!in_valid || !in_stall) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					queued_req = pending_reqs.pop_front();
					in_valid <= 1'b1;
					operation <= queued_req.operation;
					shift_value <= queued_req.shift_value;
					shift_length <= queued_req.shift_length;
					tdo_level <= queued_req.tdo_level;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		jss_pkg::res_t  want;
		jss_pkg::item_t seen;
		if (arst_n) begin
			if (res_taken) begin
				if (expected_pulses.size() == 0) begin
					errors++;
					$error("unexpected result: tms %0b tdi %0b pulse %0b", tms_out, tdi_out,
						pulse);
				end else begin
					want = expected_pulses.pop_front();
					check_field("tms_out", 32'(want.tms_out), 32'(tms_out));
					check_field("tdi_out", 32'(want.tdi_out), 32'(tdi_out));
					check_field("pulse", 32'(want.pulse), 32'(pulse));
					check_field("busy_res", 32'(want.busy_res), 32'(busy_res));
					check_field("done_res", 32'(want.done_res), 32'(done_res));
					check_field("captured_data", want.captured_data, captured_data);
					check_field("rejected", 32'(want.rejected), 32'(rejected));
				end
			end
			if (req_taken) begin
				seen.operation = operation;
				seen.shift_value = shift_value;
				seen.shift_length = shift_length;
				seen.tdo_level = tdo_level;
				expected_pulses.push_back(predict_pulse(seen));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_taken || res_taken) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("jtag_scan_sequencer_top: mismatch");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic push_req(logic [2:0] op, logic [31:0] value, logic [5:0] len, logic tdo);
		jss_pkg::item_t it;
		it.operation = op;
		it.shift_value = value;
		it.shift_length = len;
		it.tdo_level = tdo;
		pending_reqs.push_back(it);
	endtask

	task automatic push_noise();
		if ($urandom_range(1))
			push_req(3'($urandom_range(jss_pkg::OP_SHIFT_DR, jss_pkg::OP_TAP_RESET)),
				$urandom, 6'($urandom_range(63)), 1'($urandom_range(1)));
		else
			push_req(3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)), $urandom,
				6'($urandom_range(63)), 1'($urandom_range(1)));
	endtask

	task automatic run_scan(logic [2:0] op, logic [31:0] value, logic [5:0] len);
		int ticks;
		int eff_len;
		eff_len = (len == 0) ? 1 : (len > jss_pkg::SHIFT_WIDTH) ? jss_pkg::SHIFT_WIDTH : len;
		case (op)
			jss_pkg::OP_TAP_RESET: ticks = jss_pkg::RESET_PULSES;
			jss_pkg::OP_GO_IDLE:   ticks = 1;
			jss_pkg::OP_SHIFT_IR:  ticks = jss_pkg::IR_PREFIX + eff_len + 2;
			default:               ticks = jss_pkg::DR_PREFIX + eff_len + 2;
		endcase
		push_req(op, value, len, 1'($urandom_range(1)));
		items_made += ticks + 1;
		repeat (ticks) begin
			if ($urandom_range(99) < 6)
				push_noise();
			push_req(jss_pkg::OP_TICK, $urandom, 6'($urandom_range(63)),
				1'($urandom_range(1)));
		end
	endtask

	task automatic run_random_scan();
		int          sel;
		logic [2:0]  op;
		logic [5:0]  len;
		sel = $urandom_range(99);
		op = (sel < 10) ? jss_pkg::OP_TAP_RESET : (sel < 20) ? jss_pkg::OP_GO_IDLE :
			(sel < 60) ? jss_pkg::OP_SHIFT_IR : jss_pkg::OP_SHIFT_DR;
		sel = $urandom_range(99);
		len = (sel < 10) ? 6'd0 : (sel < 15) ? 6'($urandom_range(63, 32)) :
			(sel < 35) ? 6'($urandom_range(31, 9)) : 6'($urandom_range(8, 1));
		if ($urandom_range(99) < 5)
			push_req(jss_pkg::OP_TICK, $urandom, 6'($urandom_range(63)),
				1'($urandom_range(1)));
		if ($urandom_range(99) < 5)
			push_req(3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)), $urandom,
				6'($urandom_range(63)), 1'($urandom_range(1)));
		run_scan(op, $urandom, len);
	endtask

	task automatic drain();
		while (pending_reqs.size() != 0 || in_valid || expected_pulses.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(int unsigned send_pct, int unsigned stall_pct, int quota);
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		items_made = 0;
		while (items_made < quota)
			run_random_scan();
		drain();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 14;
		recv_stall_pct = 87;
		// idle tick and spare codes: ignored
		push_req(jss_pkg::OP_TICK, 32'hFFFF_FFFF, 6'd63, 1'b1);
		push_req(OP_SPARE_FIRST, 32'hFFFF_FFFF, 6'd63, 1'b1);
		push_req(OP_SPARE_MID, 32'h0000_0000, 6'd0, 1'b0);
		push_req(OP_SPARE_LAST, 32'hFFFF_FFFF, 6'd63, 1'b1);
		// tap reset with a command dropped while busy
		push_req(jss_pkg::OP_TAP_RESET, '0, '0, 1'b0);
		push_req(jss_pkg::OP_TICK, '0, '0, 1'b1);
		push_req(jss_pkg::OP_GO_IDLE, '0, '0, 1'b0);
		repeat (4) push_req(jss_pkg::OP_TICK, '0, '0, 1'b1);
		push_req(jss_pkg::OP_GO_IDLE, '0, '0, 1'b0);
		push_req(jss_pkg::OP_TICK, '0, '0, 1'b0);
		// shortest IR scan, length zero clamps to one
		push_req(jss_pkg::OP_SHIFT_IR, 32'hFFFF_FFFF, 6'd0, 1'b0);
		push_req(jss_pkg::OP_SHIFT_DR, '0, 6'd63, 1'b1);
		repeat (8) push_req(jss_pkg::OP_TICK, 32'hFFFF_FFFF, 6'd63, 1'b1);
		drain();
		run_scan(jss_pkg::OP_SHIFT_DR, 32'hFFFF_FFFF, 6'd63);
		run_scan(jss_pkg::OP_SHIFT_IR, 32'hA5A5_5A5A, 6'd32);
		run_phase(14, 87, 170);
		run_phase(87, 14, 200);
		run_phase(0, 0, 200);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && expected_pulses.size() == 0)
			$display("jtag_scan_sequencer_top: match");
		else
			$display("jtag_scan_sequencer_top: mismatch");
		$finish;
	end
endmodule
`default_nettype wire

[files.f]
src/jss_pkg.sv
src/jss_core.sv
src/jtag_scan_sequencer_top.sv
bench/jtag_scan_sequencer_top_tb.sv
